// ===== rtl/mrm_pkg.sv =====
// Package for the Modbus RTU read master: job record, configuration record,
// result kind codes and the CRC-16 byte update. No dependencies.
package mrm_pkg;

	localparam logic       KIND_TX      = 1'b0;
	localparam logic       KIND_READING = 1'b1;

	localparam logic       TGT_DIRECTION = 1'b0;
	localparam logic       TGT_LEVEL     = 1'b1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Request frame: six header bytes, then CRC low and CRC high
	localparam int         REQ_BYTES     = 8;
	localparam int         REQ_CRC_START = 6;

	// Job queue between front and back
	localparam int         QUEUE_DEPTH = 4;
	localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam logic [1:0] REG_STATION    = 2'd0;
	localparam logic [1:0] REG_FUNCTION   = 2'd1;
	localparam logic [1:0] REG_COUNT      = 2'd2;
	localparam logic [1:0] REG_BYTE_COUNT = 2'd3;

	typedef struct packed {
		logic [7:0]  station_address;
		logic [7:0]  function_code;
		logic [15:0] register_count;
		logic [7:0]  expected_byte_count;
	} cfg_t;

	// One unit of work for the back end: a query to send or a reading to report
	typedef struct packed {
		logic        is_query;
		logic [15:0] register_address;
		logic        reading_target;
		logic [15:0] reading_value;
	} job_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/mrm_if.sv =====
// Request channel interfaces for the Modbus RTU read master.
// Depends on nothing; used by all modules that touch the channels.
interface mrm_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] register_address;
	logic        target;
	logic [7:0]  rx_byte;

	modport source (output valid, cmd, register_address, target, rx_byte, input ready);
	modport sink   (input valid, cmd, register_address, target, rx_byte, output ready);
endinterface

interface mrm_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic        reading_target;
	logic [15:0] reading_value;
	logic [15:0] direction_held;
	logic [15:0] level_held;

	modport source (output valid, kind, tx_byte, last, reading_target, reading_value,
		direction_held, level_held, input ready);
	modport sink   (input valid, kind, tx_byte, last, reading_target, reading_value,
		direction_held, level_held, output ready);
endinterface

// ===== rtl/mrm_queue.sv =====
// Short job queue between the front and back ends.
// Depends on mrm_pkg.
module mrm_queue
	import mrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/mrm_front.sv =====
// Front end: takes requests, runs the response header matcher and data
// capture, and queues query and completed-reading jobs. Depends on mrm_pkg, mrm_if.
module mrm_front
	import mrm_pkg::*;
#(
	parameter int RESPONSE_LENGTH = 7
) (
	input  logic      clk,
	input  logic      arst_n,
	mrm_in_if.sink    in_ch,
	input  cfg_t      cfg,
	input  logic      queue_full,
	output logic      push,
	output job_t      push_job
);

	localparam int            PW        = $clog2(RESPONSE_LENGTH);
	localparam logic [PW-1:0] POS_START = PW'(0);
	localparam logic [PW-1:0] POS_FUNC  = PW'(1);
	localparam logic [PW-1:0] POS_COUNT = PW'(2);
	localparam logic [PW-1:0] POS_HIGH  = PW'(3);
	localparam logic [PW-1:0] POS_LOW   = PW'(4);
	localparam logic [PW-1:0] POS_LAST  = PW'(RESPONSE_LENGTH - 1);

	logic [PW-1:0] pos_q;
	logic [15:0]   data_q;
	logic          pend_valid_q;
	logic          pend_tgt_q;

	logic          accept;
	logic          is_rx;
	logic          at_end;
	logic [15:0]   data_fin;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && !queue_full;
	assign is_rx       = in_ch.cmd;
	assign at_end      = (pos_q >= POS_LAST);
	assign data_fin    = (pos_q == POS_LOW) ? {data_q[15:8], in_ch.rx_byte} : data_q;

	always_comb begin
		push_job.is_query         = !is_rx;
		push_job.register_address = in_ch.register_address;
		push_job.reading_target   = pend_tgt_q;
		push_job.reading_value    = data_fin;
		push = accept && (!is_rx || (at_end && pend_valid_q));
	end

	always_ff @(posedge clk) begin
		if (accept && is_rx) begin
			if (pos_q == POS_HIGH && !at_end) begin
				data_q <= {in_ch.rx_byte, data_q[7:0]};
			end else if (pos_q == POS_LOW) begin
				data_q <= {data_q[15:8], in_ch.rx_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_START;
			pend_valid_q <= 1'b0;
			pend_tgt_q   <= TGT_DIRECTION;
		end else if (accept) begin
			if (!is_rx) begin
				pend_valid_q <= 1'b1;
				pend_tgt_q   <= in_ch.target;
			end else if (at_end) begin
				pos_q <= POS_START;
			end else if (pos_q == POS_START) begin
				if (in_ch.rx_byte == cfg.station_address) begin
					pos_q <= POS_FUNC;
				end
			end else if (pos_q == POS_FUNC) begin
				pos_q <= (in_ch.rx_byte == cfg.function_code) ? POS_COUNT : POS_START;
			end else if (pos_q == POS_COUNT) begin
				pos_q <= (in_ch.rx_byte == cfg.expected_byte_count) ? POS_HIGH : POS_START;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mrm_back.sv =====
// Back end: serialises queued queries into request bytes with a running
// CRC-16, applies completed readings and drives the output register.
// Depends on mrm_pkg, mrm_if.
module mrm_back
	import mrm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mrm_out_if.source out_ch,
	input  cfg_t      cfg,
	input  logic      queue_empty,
	input  job_t      head,
	output logic      pop
);

	logic [2:0]  cnt_q;
	logic [15:0] crc_q;
	logic [15:0] dir_q;
	logic [15:0] lvl_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_q;
	logic        last_q;
	logic        rtgt_q;
	logic [15:0] rval_q;

	logic        advance;
	logic        produce;
	logic [15:0] crc_cur;
	logic [7:0]  req_byte;
	logic        last_byte;
	logic [15:0] dir_next;
	logic [15:0] lvl_next;

	assign advance   = !out_valid_q || out_ch.ready;
	assign produce   = advance && !queue_empty;
	assign crc_cur   = (cnt_q == 3'd0) ? CRC_INIT : crc_q;
	assign last_byte = (cnt_q == 3'(REQ_BYTES - 1));
	assign pop       = produce && (!head.is_query || last_byte);

	always_comb begin
		case (cnt_q)
			3'd0:    req_byte = cfg.station_address;
			3'd1:    req_byte = cfg.function_code;
			3'd2:    req_byte = head.register_address[15:8];
			3'd3:    req_byte = head.register_address[7:0];
			3'd4:    req_byte = cfg.register_count[15:8];
			3'd5:    req_byte = cfg.register_count[7:0];
			3'd6:    req_byte = crc_q[7:0];
			default: req_byte = crc_q[15:8];
		endcase
	end

	always_comb begin
		dir_next = dir_q;
		lvl_next = lvl_q;
		if (!head.is_query) begin
			if (head.reading_target == TGT_LEVEL) begin
				lvl_next = head.reading_value;
			end else begin
				dir_next = head.reading_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			if (head.is_query) begin
				kind_q <= KIND_TX;
				tx_q   <= req_byte;
				last_q <= last_byte;
				rtgt_q <= TGT_DIRECTION;
				rval_q <= '0;
				if (cnt_q < 3'(REQ_CRC_START)) begin
					crc_q <= crc_feed(crc_cur, req_byte);
				end
			end else begin
				kind_q <= KIND_READING;
				tx_q   <= '0;
				last_q <= 1'b0;
				rtgt_q <= head.reading_target;
				rval_q <= head.reading_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			dir_q       <= '0;
			lvl_q       <= '0;
		end else if (advance) begin
			out_valid_q <= !queue_empty;
			if (produce) begin
				if (head.is_query) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					dir_q <= dir_next;
					lvl_q <= lvl_next;
				end
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.kind           = kind_q;
	assign out_ch.tx_byte        = tx_q;
	assign out_ch.last           = last_q;
	assign out_ch.reading_target = rtgt_q;
	assign out_ch.reading_value  = rval_q;
	assign out_ch.direction_held = dir_q;
	assign out_ch.level_held     = lvl_q;

endmodule

// ===== rtl/modbus_rtu_read_master.sv =====
// Top level of the Modbus RTU read master: configuration registers on an
// APB-style port, front end, job queue and back end. Depends on mrm_pkg, mrm_if.
//
//   channel  | direction | moves
//   ---------+-----------+---------------------------------------------------
//   in_ch    | sink      | request: query command or received line byte
//   out_ch   | source    | request: transmit byte or completed reading
//   APB      | slave     | station, function, register count, byte count
//
// The front end accepts a received byte or a query whenever the job queue is not
// full. The back end emits one result per cycle while out_ch is not stalled and a
// job waits: eight bytes per query (CRC over first six), one per completed reading.
// The four-entry job queue sets how far the front can run ahead of the back.
// Reset clears the matcher, pending reading, held readings and queue;
// configuration returns to station 1, function 3, count 2, byte count 2.
module modbus_rtu_read_master
	import mrm_pkg::*;
#(
	parameter int RESPONSE_LENGTH = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	mrm_in_if.sink     in_ch,
	mrm_out_if.source  out_ch,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic [1:0] reg_idx;

	logic q_push;
	job_t q_push_job;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_head;

	// Registers sit on word boundaries; drop the byte offset
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address     <= 8'd1;
			cfg_q.function_code       <= 8'd3;
			cfg_q.register_count      <= 16'd2;
			cfg_q.expected_byte_count <= 8'd2;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STATION:    cfg_q.station_address     <= pwdata[7:0];
				REG_FUNCTION:   cfg_q.function_code       <= pwdata[7:0];
				REG_COUNT:      cfg_q.register_count      <= pwdata[15:0];
				REG_BYTE_COUNT: cfg_q.expected_byte_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STATION:    prdata = {24'd0, cfg_q.station_address};
			REG_FUNCTION:   prdata = {24'd0, cfg_q.function_code};
			REG_COUNT:      prdata = {16'd0, cfg_q.register_count};
			REG_BYTE_COUNT: prdata = {24'd0, cfg_q.expected_byte_count};
			default:        prdata = '0;
		endcase
	end

	// Classify requests and track the response header
	mrm_front #(
		.RESPONSE_LENGTH(RESPONSE_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg_q),
		.queue_full (q_full),
		.push       (q_push),
		.push_job   (q_push_job)
	);

	// Hold jobs so that a stalled output does not stop reception
	mrm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// Serialise queries and report readings in order
	mrm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.out_ch      (out_ch),
		.cfg         (cfg_q),
		.queue_empty (q_empty),
		.head        (q_head),
		.pop         (q_pop)
	);

endmodule
